/* src/tcw_pkg.sv */
// Shared types and constants of the text console writer.
// Depends on nothing; imported by tcw_cursor, the top level and the testbench.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = ATTR_W + CHAR_W;
    localparam int INDEX_W  = 11;
    localparam int POS_W    = 11;

    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CHAR};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef struct packed {
        logic step;
        logic newline;
        logic home;
    } t_cur_cmd;

endpackage

/* src/tcw_screen_ram.sv */
// Screen cell memory: one write port, one read port, registered read data.
// Depends on nothing.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcw_cursor.sv */
// Cursor tracker: column, row base and linear position, with wrap and scroll detect.
// Depends on tcw_pkg.
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cur_cmd                            i_cmd,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     o_pos,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     o_next_pos,
    output logic                                o_scroll
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int LAST_BASE = CELLS - COLUMNS;

    logic [COL_W-1:0]   r_col, n_col;
    logic [CELL_AW-1:0] r_base, n_base;
    logic [CELL_AW-1:0] r_pos, n_pos;
    logic               wrap;
    logic               last_row;

    assign wrap     = i_cmd.newline || (i_cmd.step && (r_col == COL_W'(COLUMNS - 1)));
    assign last_row = (r_base == CELL_AW'(LAST_BASE));

    always_comb begin
        n_col  = r_col;
        n_base = r_base;
        n_pos  = r_pos;
        if (i_cmd.home) begin
            n_col  = '0;
            n_base = '0;
            n_pos  = '0;
        end else if (wrap) begin
            n_col = '0;
            if (last_row) begin
                n_pos = r_base;
            end else begin
                n_base = r_base + CELL_AW'(COLUMNS);
                n_pos  = r_base + CELL_AW'(COLUMNS);
            end
        end else if (i_cmd.step) begin
            n_col = r_col + COL_W'(1);
            n_pos = r_pos + CELL_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_base <= '0;
            r_pos  <= '0;
        end else begin
            r_col  <= n_col;
            r_base <= n_base;
            r_pos  <= n_pos;
        end
    end

    assign o_pos      = r_pos;
    assign o_next_pos = n_pos;
    assign o_scroll   = wrap && last_row && !i_cmd.home;

endmodule

/* src/text_console_writer_unit.sv */
// Top level of the text console writer: sequencer, attribute register, result register.
// Depends on tcw_pkg, tcw_screen_ram and tcw_cursor.
//
// A put of an ordinary character, a newline that does not scroll and an unused opcode
// load their result from the idle state when the output register is free. A read passes
// through accept, memory read and result. A clear and a put that scrolls walk the whole
// screen, since every cell moves or is blanked through the single write port of the
// screen memory. After reset the block sweeps the memory to spaces with attribute 0x0F
// before it takes the first item; configuration writes are taken at any time. Results
// wait in an output register, one item deep.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ATTR_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [INDEX_W-1:0]  i_cell_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [POS_W-1:0]    o_cursor_position,
    output logic [CELL_W-1:0]   o_cell_value,
    output logic                o_scrolled
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int LAST_BASE = CELLS - COLUMNS;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DRAIN,
        S_BLANK,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CELL_AW-1:0] r_addr;
    logic               r_cp_pend;
    logic [CELL_AW-1:0] r_cp_addr;
    logic               r_rd_ok;
    logic [ATTR_W-1:0]  r_attr;
    logic [CELL_AW-1:0] r_pend_pos;
    logic [CELL_W-1:0]  r_pend_val;
    logic               r_pend_scr;
    logic               r_out_valid;
    logic [CELL_AW-1:0] r_out_pos;
    logic [CELL_W-1:0]  r_out_val;
    logic               r_out_scr;

    logic               in_acc;
    logic               out_free;
    logic               out_load;
    logic               is_nl;
    logic               in_range;
    t_opcode            op;
    t_cur_cmd           cur_cmd;
    logic [CELL_AW-1:0] cur_pos;
    logic [CELL_AW-1:0] cur_next;
    logic               cur_scroll;
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic [CELL_AW-1:0] raddr;
    logic [CELL_W-1:0]  rdata;
    logic               last_addr;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign op         = t_opcode'(i_opcode);
    assign is_nl      = (i_char_code == NEWLINE_CHAR);
    assign in_range   = (32'(i_cell_index) < 32'(CELLS));
    assign last_addr  = (r_addr == CELL_AW'(CELLS - 1));
    assign out_load   = out_free && ((r_state == S_DONE) ||
                        (in_acc && (op != OP_READ) && (op != OP_CLEAR) && !cur_scroll));

    always_comb begin
        cur_cmd.step    = in_acc && (op == OP_PUT) && !is_nl;
        cur_cmd.newline = in_acc && (op == OP_PUT) && is_nl;
        cur_cmd.home    = in_acc && (op == OP_CLEAR);
    end

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cur_cmd),
        .o_pos      (cur_pos),
        .o_next_pos (cur_next),
        .o_scroll   (cur_scroll)
    );

    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = {r_attr, SPACE_CHAR};
        case (r_state)
            S_INIT: begin
                we    = 1'b1;
                wdata = RESET_CELL;
            end
            S_IDLE: begin
                we    = cur_cmd.step;
                waddr = cur_pos;
                wdata = {r_attr, i_char_code};
            end
            S_SCROLL, S_DRAIN: begin
                we    = r_cp_pend;
                waddr = r_cp_addr;
                wdata = rdata;
            end
            S_BLANK: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign raddr = (r_state == S_SCROLL) ? r_addr : CELL_AW'(i_cell_index);

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (CELL_AW),
        .DW    (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (last_addr) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + CELL_AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_pend_pos <= cur_next;
                        r_pend_val <= '0;
                        r_pend_scr <= 1'b0;
                        case (op)
                            OP_READ: begin
                                r_rd_ok <= in_range;
                                r_state <= S_READ;
                            end
                            OP_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= S_BLANK;
                            end
                            default: begin
                                if (op == OP_PUT && cur_scroll) begin
                                    r_pend_scr <= 1'b1;
                                    r_addr     <= CELL_AW'(COLUMNS);
                                    r_cp_pend  <= 1'b0;
                                    r_state    <= S_SCROLL;
                                end else if (out_free) begin
                                    r_out_pos <= cur_next;
                                    r_out_val <= '0;
                                    r_out_scr <= 1'b0;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_pend_val <= r_rd_ok ? rdata : '0;
                    r_state    <= S_DONE;
                end
                S_SCROLL: begin
                    r_cp_pend <= 1'b1;
                    r_cp_addr <= r_addr - CELL_AW'(COLUMNS);
                    if (last_addr) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + CELL_AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_cp_pend <= 1'b0;
                    r_addr    <= CELL_AW'(LAST_BASE);
                    r_state   <= S_BLANK;
                end
                S_BLANK: begin
                    if (last_addr) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr <= r_addr + CELL_AW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_pos <= r_pend_pos;
                        r_out_val <= r_pend_val;
                        r_out_scr <= r_pend_scr;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = POS_W'(r_out_pos);
    assign o_cell_value      = r_out_val;
    assign o_scrolled        = r_out_scr;

    a_copy_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> (r_state == S_SCROLL || r_state == S_DRAIN))
        else $error("row copy write pending outside scroll");

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(cur_pos) < 32'(CELLS))
        else $error("cursor beyond last cell");

    a_scroll_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_cursor_position == POS_W'(LAST_BASE)))
        else $error("scrolled item not on start of last row");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op == OP_READ) |=> (r_state == S_READ && !we))
        else $error("read item did not enter memory read");

endmodule

/* tb/sv/tb_text_console_writer_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench of text_console_writer_unit: a screen scoreboard predicts every
// result, and tasks drive put, read, clear and unused items under varied handshake stalls.
// Depends on tcw_pkg and text_console_writer_unit.
module tb_text_console_writer_unit;
    import tcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] value;
        logic              scrolled;
    } t_console_result;

    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELLS];
        int unsigned       col;
        int unsigned       row;
        logic [ATTR_W-1:0] attribute;
        t_console_result   expected_results [$];
        int                errors;

        function new();
            for (int i = 0; i < CELLS; i++) cells[i] = RESET_CELL;
            col = 0;
            row = 0;
            attribute = RESET_ATTR;
            errors = 0;
        endfunction

        function void set_attribute(logic [ATTR_W-1:0] a);
            attribute = a;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function int cursor_pos();
            return int'(row * COLUMNS + col);
        endfunction

        function logic next_row();
            col = 0;
            row++;
            if (row < ROWS) return 1'b0;
            for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attribute, SPACE_CHAR};
            row = ROWS - 1;
            return 1'b1;
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [INDEX_W-1:0] idx);
            t_console_result r;
            r.value = '0;
            r.scrolled = 1'b0;
            case (op)
                OP_PUT: begin
                    if (ch == NEWLINE_CHAR) begin
                        r.scrolled = next_row();
                    end else begin
                        cells[row * COLUMNS + col] = {attribute, ch};
                        col++;
                        if (col >= COLUMNS) r.scrolled = next_row();
                    end
                end
                OP_READ: begin
                    if (idx < CELLS) r.value = cells[idx];
                end
                OP_CLEAR: begin
                    for (int i = 0; i < CELLS; i++) cells[i] = {attribute, SPACE_CHAR};
                    col = 0;
                    row = 0;
                end
                default: ;
            endcase
            r.pos = POS_W'(row * COLUMNS + col);
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [POS_W-1:0] pos, logic [CELL_W-1:0] value,
                                   logic scrolled);
            t_console_result want;
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: cursor_position %0d", pos);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (pos !== want.pos) begin
                $error("cursor_position: expected %0d, actual %0d", want.pos, pos);
                errors++;
            end
            if (value !== want.value) begin
                $error("cell_value: expected 0x%04h, actual 0x%04h", want.value, value);
                errors++;
            end
            if (scrolled !== want.scrolled) begin
                $error("scrolled: expected %0b, actual %0b", want.scrolled, scrolled);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [ATTR_W-1:0]   i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OPCODE_W-1:0] i_opcode;
    logic [CHAR_W-1:0]   i_char_code;
    logic [INDEX_W-1:0]  i_cell_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [POS_W-1:0]    o_cursor_position;
    logic [CELL_W-1:0]   o_cell_value;
    logic                o_scrolled;

    console_scoreboard board;
    int                send_gap_pct;
    int                recv_stall_pct;
    bit                start_hold;
    int                hold_left;
    int                items_sent;
    int unsigned       cycle_count;

    text_console_writer_unit #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_char_code      (i_char_code),
        .i_cell_index     (i_cell_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_position(o_cursor_position),
        .o_cell_value     (o_cell_value),
        .o_scrolled       (o_scrolled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (start_hold) begin
            hold_left = HOLD_CYCLES;
            start_hold = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) board.note_item(i_opcode, i_char_code, i_cell_index);
            if (o_out_valid && i_out_ready)
                board.check_result(o_cursor_position, o_cell_value, o_scrolled);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
                             logic [INDEX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_opcode = op;
        i_char_code = ch;
        i_cell_index = idx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_item(OP_PUT, ch, INDEX_W'($urandom));
    endtask

    task automatic read_cell(logic [INDEX_W-1:0] idx);
        send_item(OP_READ, CHAR_W'($urandom), idx);
    endtask

    task automatic read_somewhere();
        int p;
        p = board.cursor_pos();
        case ($urandom_range(3))
            0: read_cell(INDEX_W'($urandom_range(2047)));
            1: read_cell(INDEX_W'((p > 2) ? p - $urandom_range(2) : p));
            2: read_cell(INDEX_W'(CELLS - COLUMNS + $urandom_range(COLUMNS - 1)));
            default: read_cell(INDEX_W'($urandom_range(COLUMNS - 1)));
        endcase
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic load_attribute(logic [ATTR_W-1:0] a);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = a;
        @(posedge i_clk);
        board.set_attribute(a);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic run_directed();
        read_cell(INDEX_W'(0));
        read_cell(INDEX_W'(CELLS - 1));
        read_cell(INDEX_W'(CELLS));
        read_cell('1);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        read_cell(INDEX_W'(0));
        read_cell(INDEX_W'(1));
        read_cell(INDEX_W'(2));
        send_item(OP_UNUSED, 8'h00, '0);
        put_char(NEWLINE_CHAR);
        put_char(8'h7F);
        read_cell(INDEX_W'(COLUMNS));
        read_cell(INDEX_W'(COLUMNS + 1));
        send_item(OP_UNUSED, 8'hFF, '1);
        send_item(OP_CLEAR, 8'hFF, '1);
        read_cell(INDEX_W'(0));
        read_cell(INDEX_W'(2));
        put_char(SPACE_CHAR);
    endtask

    task automatic run_text(int n_items);
        int target;
        int kind;
        int len;
        logic [CHAR_W-1:0] ch;
        target = items_sent + n_items;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 5) begin
                send_item(OP_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
            end else if (kind < 8) begin
                send_item(OP_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
            end else if (kind < 20) begin
                len = $urandom_range(3, 20);
                if (len > target - items_sent) len = target - items_sent;
                repeat (len) put_char(NEWLINE_CHAR);
            end else if (kind < 25) begin
                read_cell(INDEX_W'($urandom_range(2047)));
            end else begin
                len = ($urandom_range(7) == 0) ? $urandom_range(70, 90) : $urandom_range(5);
                if (len > target - items_sent) len = target - items_sent;
                repeat (len) begin
                    do ch = CHAR_W'($urandom); while (ch == NEWLINE_CHAR);
                    put_char(ch);
                    if ($urandom_range(99) < 20) read_somewhere();
                end
                if ($urandom_range(3) != 0) put_char(NEWLINE_CHAR);
            end
        end
    endtask

    initial begin
        board = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_PUT;
        i_char_code = '0;
        i_cell_index = '0;
        i_out_ready = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        start_hold = 1'b0;
        hold_left = 0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        finish_burst();

        load_attribute(8'h00);
        run_text(90);
        finish_burst();

        load_attribute(8'hFF);
        send_gap_pct = 50;
        run_text(90);
        finish_burst();

        load_attribute(ATTR_W'($urandom));
        send_gap_pct = 0;
        recv_stall_pct = 50;
        run_text(45);
        finish_burst();
        run_text(45);
        finish_burst();

        load_attribute(ATTR_W'($urandom));
        send_gap_pct = 8;
        recv_stall_pct = 8;
        run_text(90);
        finish_burst();

        load_attribute(RESET_ATTR);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        start_hold = 1'b1;
        run_text(40);
        finish_burst();

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
